FILE: sv/irc_message_tokenizer_core_defines.svh
// Assertion macros for the IRC message tokenizer.
// Used by irc_message_tokenizer_core; expects clk_i and rst_ni in scope.
`ifndef IRC_MESSAGE_TOKENIZER_CORE_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define IRC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the same cycle
`define IRC_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);
`else
`define IRC_ASSERT(lbl, cond, msg)
`define IRC_ASSERT_IMPL(lbl, trig, cons, msg)
`endif

`endif

FILE: sv/irc_pkg.sv
// Package for the IRC message tokenizer: types, codes and character constants.
// No dependencies.
`default_nettype none

package irc_pkg;

  // Argument limit and field widths
  localparam int unsigned ARG_LIMIT = 64;
  localparam int unsigned ArgIdxW   = 6;
  localparam int unsigned ArgCntW   = 7;

  // Characters of interest
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Line parser phase
  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhPrefix = 3'd1,
    PhSkip   = 3'd2,
    PhArgs   = 3'd3,
    PhDone   = 3'd4
  } phase_e;

  // Result kind codes
  typedef enum logic [2:0] {
    KindDrop   = 3'd0,
    KindOrigin = 3'd1,
    KindArg    = 3'd2,
    KindNewArg = 3'd3,
    KindDone   = 3'd4,
    KindError  = 3'd5
  } kind_e;

  // One result transaction
  typedef struct packed {
    kind_e               kind;
    logic [7:0]          out_byte;
    logic [ArgIdxW-1:0]  arg_index;
    logic                in_trailing;
    logic [ArgCntW-1:0]  arg_count;
    logic                arg_overflow;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/irc_message_tokenizer_core.sv
// IRC message tokenizer: one character in, one result out per transaction.
// The input register feeds the result register through the parser logic.
// Throughput: one character per cycle; a stalled result register holds the input.
// Reset (rst_ni, async, active low) empties both registers and returns the
// parser to line start with argument index, trailing and overflow flags cleared.
`default_nettype none
`include "irc_message_tokenizer_core_defines.svh"

module irc_message_tokenizer_core
  import irc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         char_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              kind_o,
  output logic [7:0]              out_byte_o,
  output logic [ArgIdxW-1:0]      arg_index_o,
  output logic                    in_trailing_o,
  output logic [ArgCntW-1:0]      arg_count_o,
  output logic                    arg_overflow_o
);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_char_q;

  // Parser state
  phase_e             phase_q, phase_d;
  logic [ArgIdxW-1:0] cur_arg_q, cur_arg_d;
  logic               split_q, split_d;
  logic               trail_q, trail_d;
  logic               ovf_q, ovf_d;

  // Result register
  logic    out_vld_q;
  result_t res_q, res_d;

  logic move;
  logic in_take;

  // Advance when the result register is free or being drained
  assign move       = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~move;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Next state and result for the character in the input register
  always_comb begin
    logic               is_zero;
    logic               is_colon;
    logic               is_space;
    logic               is_crlf;
    logic               do_arg;
    logic [ArgCntW-1:0] cnt_plus;

    is_zero  = (in_char_q == ChNul);
    is_colon = (in_char_q == ChColon);
    is_space = (in_char_q == ChSpace);
    is_crlf  = (in_char_q == ChCr) || (in_char_q == ChLf);
    cnt_plus = {1'b0, cur_arg_q} + ArgCntW'(1);
    do_arg   = 1'b0;

    phase_d   = phase_q;
    cur_arg_d = cur_arg_q;
    split_d   = split_q;
    trail_d   = trail_q;
    ovf_d     = ovf_q;

    res_d           = '0;
    res_d.kind      = KindDrop;

    if (is_zero) begin
      case (phase_q)
        PhPrefix: res_d.kind = KindError;
        PhDone:   res_d.kind = KindDrop;
        default: begin
          res_d.kind      = KindDone;
          res_d.arg_count = cnt_plus;
        end
      endcase
    end else begin
      case (phase_q)
        PhStart: begin
          if (is_colon) begin
            phase_d = PhPrefix;
          end else begin
            do_arg = 1'b1;
          end
        end
        PhPrefix: begin
          if (is_space) begin
            phase_d = PhSkip;
          end else begin
            res_d.kind     = KindOrigin;
            res_d.out_byte = in_char_q;
          end
        end
        PhSkip: begin
          if (!is_space) begin
            do_arg = 1'b1;
          end
        end
        PhArgs: do_arg = 1'b1;
        default: res_d.kind = KindDrop;
      endcase
    end

    // Argument mode character handling
    if (do_arg) begin
      phase_d = PhArgs;
      if (!trail_q && split_q && is_colon) begin
        trail_d    = 1'b1;
        split_d    = 1'b0;
        res_d.kind = KindDrop;
      end else if (!trail_q && is_space) begin
        if (cnt_plus < ArgCntW'(ARG_LIMIT)) begin
          cur_arg_d = cnt_plus[ArgIdxW-1:0];
        end else begin
          ovf_d = 1'b1;
        end
        split_d    = 1'b1;
        res_d.kind = KindNewArg;
      end else if (is_crlf) begin
        res_d.arg_count = cnt_plus;
        phase_d         = PhDone;
        split_d         = 1'b0;
        res_d.kind      = KindDone;
      end else begin
        split_d        = 1'b0;
        res_d.kind     = KindArg;
        res_d.out_byte = in_char_q;
      end
    end

    // Report state after this character
    res_d.arg_index    = cur_arg_d;
    res_d.in_trailing  = trail_d;
    res_d.arg_overflow = ovf_d;

    // Clear for the next line at end of string
    if (is_zero) begin
      phase_d   = PhStart;
      cur_arg_d = '0;
      split_d   = 1'b0;
      trail_d   = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  // Input register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= char_code_i;
    end
  end

  // Parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      cur_arg_q <= '0;
      split_q   <= 1'b0;
      trail_q   <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (move) begin
      phase_q   <= phase_d;
      cur_arg_q <= cur_arg_d;
      split_q   <= split_d;
      trail_q   <= trail_d;
      ovf_q     <= ovf_d;
    end
  end

  // Result register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  // Drive outputs
  assign out_valid_o    = out_vld_q;
  assign kind_o         = res_q.kind;
  assign out_byte_o     = res_q.out_byte;
  assign arg_index_o    = res_q.arg_index;
  assign in_trailing_o  = res_q.in_trailing;
  assign arg_count_o    = res_q.arg_count;
  assign arg_overflow_o = res_q.arg_overflow;

  // Assertions
  `IRC_ASSERT_IMPL(a_count_with_done, out_vld_q,
    ((res_q.kind == KindDone) == (res_q.arg_count != '0)), "arg_count set without line complete")
  `IRC_ASSERT_IMPL(a_byte_only_data, out_vld_q && res_q.kind != KindOrigin && res_q.kind != KindArg,
    res_q.out_byte == 8'h00, "byte carried on non-data kind")
  `IRC_ASSERT_IMPL(a_prefix_clean, phase_q == PhPrefix,
    cur_arg_q == '0 && !trail_q && !ovf_q, "argument state set inside prefix")
  `IRC_ASSERT_IMPL(a_trail_phase, trail_q,
    phase_q == PhArgs || phase_q == PhDone, "trailing mode outside argument phase")

endmodule

`default_nettype wire

FILE: bench/tb_irc_message_tokenizer_core.sv
// Self-checking testbench for irc_message_tokenizer_core: a directed table, then random lines.
// Depends on irc_pkg for the phase and kind enums, the result struct and the character constants.
`timescale 1ns / 100ps

module tb_irc_message_tokenizer_core;
  import irc_pkg::*;

  localparam int unsigned CycleLimit    = 500_000;
  localparam int unsigned ItemsPerPhase = 375;
  localparam int unsigned NumDirected   = 25;
  localparam int unsigned SettleCycles  = 8;

  // One row of the directed table; the expected fields matter only when typed is set
  typedef struct {
    logic [7:0]         code;
    bit                 typed;
    kind_e              kind;
    logic [7:0]         ob;
    logic [ArgIdxW-1:0] idx;
    bit                 trail;
    logic [ArgCntW-1:0] cnt;
    bit                 ovf;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i  = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [2:0]         kind_o;
  logic [7:0]         out_byte_o;
  logic [ArgIdxW-1:0] arg_index_o;
  logic               in_trailing_o;
  logic [ArgCntW-1:0] arg_count_o;
  logic               arg_overflow_o;

  // Expected token transactions, oldest first
  result_t     token_q[$];
  logic [7:0]  line_chars[$];
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Tokenizer state as seen by the predictor
  phase_e      tok_phase       = PhStart;
  int unsigned tok_arg         = 0;
  bit          tok_after_split = 1'b0;
  bit          tok_trailing    = 1'b0;
  bit          tok_overflow    = 1'b0;

  // Directed table: prefix edges, empty lines, trailing colon, line-end junk
  dir_row_t dir_rows [NumDirected] = '{
    '{8'h00, 1'b1, KindDone,   8'h00, 6'd0, 1'b0, 7'd1, 1'b0},  // empty line
    '{8'h3A, 1'b1, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // open prefix
    '{8'h61, 1'b1, KindOrigin, 8'h61, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h0D, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // CR is data in prefix
    '{8'h00, 1'b1, KindError,  8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // end inside prefix
    '{8'h3A, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'hFF, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h20, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // close prefix
    '{8'h20, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // skipped space
    '{8'h3A, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // colon after prefix
    '{8'h20, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h20, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // empty argument
    '{8'h3A, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // start trailing
    '{8'h20, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h01, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h80, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h0A, 1'b1, KindDone,   8'h00, 6'd2, 1'b1, 7'd3, 1'b0},
    '{8'h78, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // junk after line end
    '{8'h0D, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h00, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h62, 1'b1, KindArg,    8'h62, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h7F, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},
    '{8'h00, 1'b1, KindDone,   8'h00, 6'd0, 1'b0, 7'd1, 1'b0},
    '{8'h0D, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0},  // CR at line start
    '{8'h00, 1'b0, KindDrop,   8'h00, 6'd0, 1'b0, 7'd0, 1'b0}
  };

  irc_message_tokenizer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .arg_index_o    (arg_index_o),
    .in_trailing_o  (in_trailing_o),
    .arg_count_o    (arg_count_o),
    .arg_overflow_o (arg_overflow_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Handle one non-null character in argument mode: split, trailing, line end or data
  function automatic result_t split_or_append(input logic [7:0] c);
    result_t r;
    r = '0;
    if (!tok_trailing && tok_after_split && c == ChColon) begin
      tok_trailing    = 1'b1;
      tok_after_split = 1'b0;
      r.kind          = KindDrop;
    end else if (!tok_trailing && c == ChSpace) begin
      // Saturate the index at ARG_LIMIT-1 and flag the refused split
      if (tok_arg + 1 < ARG_LIMIT) tok_arg++;
      else tok_overflow = 1'b1;
      tok_after_split = 1'b1;
      r.kind          = KindNewArg;
    end else if (c == ChCr || c == ChLf) begin
      r.arg_count     = ArgCntW'(tok_arg + 1);
      tok_phase       = PhDone;
      tok_after_split = 1'b0;
      r.kind          = KindDone;
    end else begin
      tok_after_split = 1'b0;
      r.out_byte      = c;
      r.kind          = KindArg;
    end
    return r;
  endfunction

  // Predict the token for one accepted character and advance the state
  function automatic result_t tokenize_char(input logic [7:0] c);
    result_t r;
    bit      line_end;
    r        = '0;
    line_end = 1'b0;
    if (c == ChNul) begin
      line_end = 1'b1;
      if (tok_phase == PhPrefix) begin
        r.kind = KindError;
      end else if (tok_phase == PhDone) begin
        r.kind = KindDrop;
      end else begin
        r.kind      = KindDone;
        r.arg_count = ArgCntW'(tok_arg + 1);
      end
    end else begin
      case (tok_phase)
        PhStart: begin
          if (c == ChColon) begin
            tok_phase = PhPrefix;
          end else begin
            tok_phase = PhArgs;
            r = split_or_append(c);
          end
        end
        PhPrefix: begin
          if (c == ChSpace) begin
            tok_phase = PhSkip;
          end else begin
            r.kind     = KindOrigin;
            r.out_byte = c;
          end
        end
        PhSkip: begin
          if (c != ChSpace) begin
            tok_phase = PhArgs;
            r = split_or_append(c);
          end
        end
        PhArgs: r = split_or_append(c);
        default: r.kind = KindDrop;
      endcase
    end
    r.arg_index    = ArgIdxW'(tok_arg);
    r.in_trailing  = tok_trailing;
    r.arg_overflow = tok_overflow;
    // Clear for the next line
    if (line_end) begin
      tok_phase       = PhStart;
      tok_arg         = 0;
      tok_after_split = 1'b0;
      tok_trailing    = 1'b0;
      tok_overflow    = 1'b0;
    end
    return r;
  endfunction

  // Any nonzero byte that is not a separator or a line end
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChSpace || c == ChCr || c == ChLf);
    return c;
  endfunction

  // Build one random line into line_chars, mostly well formed
  task automatic compose_line(input bit many_args);
    int unsigned shape;
    int unsigned nargs;
    int unsigned width;
    line_chars.delete();
    shape = $urandom_range(99);
    if (!many_args && shape < 12) begin
      // Noise: raw bytes, nulls included
      repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
      line_chars.push_back(ChNul);
    end else if (!many_args && shape < 17) begin
      // Broken: line ends inside the prefix
      line_chars.push_back(ChColon);
      repeat ($urandom_range(0, 4)) line_chars.push_back(word_char());
      line_chars.push_back(ChNul);
    end else begin
      if ($urandom_range(1)) begin
        line_chars.push_back(ChColon);
        repeat ($urandom_range(1, 6)) line_chars.push_back(word_char());
        repeat ($urandom_range(1, 3)) line_chars.push_back(ChSpace);
        if ($urandom_range(3) == 0) line_chars.push_back(ChColon);
      end
      many_args = many_args || ($urandom_range(39) == 0);
      nargs = many_args ? $urandom_range(62, 70) : $urandom_range(0, 5);
      width = many_args ? 2 : 5;
      for (int a = 0; a < nargs; a++) begin
        if (a != 0) repeat (($urandom_range(4) == 0) ? 2 : 1) line_chars.push_back(ChSpace);
        repeat ($urandom_range(0, width)) line_chars.push_back(word_char());
      end
      if ($urandom_range(1)) begin
        line_chars.push_back(ChSpace);
        line_chars.push_back(ChColon);
        repeat ($urandom_range(0, 6)) begin
          line_chars.push_back(($urandom_range(3) == 0) ? ChSpace : word_char());
        end
      end
      if ($urandom_range(9) < 7) begin
        line_chars.push_back($urandom_range(1) ? ChCr : ChLf);
        repeat ($urandom_range(0, 3)) line_chars.push_back(8'($urandom_range(1, 255)));
      end
      line_chars.push_back(ChNul);
    end
  endtask

  // Offer one character, hold it until accepted, then record the expected token
  task automatic send_char(input logic [7:0] c, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = tokenize_char(c);
    token_q.push_back(typed ? want : predicted);
  endtask

  // Stop sending until every expected token has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatch_cnt++;
    $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // Token side: compare each transaction with the oldest expectation, then pick the stall
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (token_q.size() == 0) begin
          mismatch_cnt++;
          $display("[%0t] unexpected token: expected none, actual kind 0x%0h", $time, kind_o);
        end else begin
          want = token_q.pop_front();
          if (kind_o !== want.kind) report_mismatch("kind", 8'(want.kind), 8'(kind_o));
          if (out_byte_o !== want.out_byte) report_mismatch("out_byte", want.out_byte, out_byte_o);
          if (arg_index_o !== want.arg_index) begin
            report_mismatch("arg_index", 8'(want.arg_index), 8'(arg_index_o));
          end
          if (in_trailing_o !== want.in_trailing) begin
            report_mismatch("in_trailing", 8'(want.in_trailing), 8'(in_trailing_o));
          end
          if (arg_count_o !== want.arg_count) begin
            report_mismatch("arg_count", 8'(want.arg_count), 8'(arg_count_o));
          end
          if (arg_overflow_o !== want.arg_overflow) begin
            report_mismatch("arg_overflow", 8'(want.arg_overflow), 8'(arg_overflow_o));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stimulus: reset, directed table, then four idling phases of random lines
  initial begin
    result_t     typed_want;
    int unsigned phase_items;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_want = '{dir_rows[i].kind, dir_rows[i].ob, dir_rows[i].idx, dir_rows[i].trail,
                     dir_rows[i].cnt, dir_rows[i].ovf};
      send_char(dir_rows[i].code, dir_rows[i].typed, typed_want);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      // Change idling between edges, then resume on a rising edge
      @(negedge clk_i);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      @(posedge clk_i);
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        compose_line(phase_items == 0);
        foreach (line_chars[j]) send_char(line_chars[j], 1'b0, '0);
        phase_items += line_chars.size();
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && token_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/irc_pkg.sv
sv/irc_message_tokenizer_core.sv
bench/tb_irc_message_tokenizer_core.sv
